>>> rtl/mkpq_pkg.sv
// ----------------------------------------------------------------------------
// mkpq_pkg: shared types and constants of the multi-key priority queue
// Entry layout, command and status codes, class lookup and the rank compare.
// ----------------------------------------------------------------------------
package mkpq_pkg;

   // Number of cells in the sorted chain.
   localparam int CAPACITY = 16;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);

   // Field widths fixed by the interface.
   localparam int TAG_W   = 16;
   localparam int AGE_W   = 7;
   localparam int CLASS_W = 2;
   localparam int CODE_W  = 4;
   localparam int TABLE_W = 20;
   localparam int OCC_W   = 5;

   // Complaint codes above this value map to the default class.
   localparam logic [CODE_W-1:0]  MAX_TABLE_CODE = 4'd9;
   localparam logic [CLASS_W-1:0] DEFAULT_CLASS  = 2'd1;
   localparam logic [TABLE_W-1:0] TABLE_RESET    = 20'd488873;

   // Command codes carried on the request side.
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_SERVE  = 1'b1;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_SERVED   = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_DROPPED  = 2'd3
   } status_type;

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [AGE_W-1:0]   age;
      logic               female;
      logic [CLASS_W-1:0] cls;
   } entry_type;

   // Operation broadcast to every cell in a cycle.
   typedef struct packed {
      logic insert;
      logic serve;
   } op_type;

   // What one cell shows its neighbors.
   typedef struct packed {
      logic      valid;
      logic      beaten;
      entry_type entry;
   } link_type;

   // Severity class of a complaint code.
   function automatic logic [CLASS_W-1:0] lookup_class(input logic [TABLE_W-1:0] table_v,
                                                       input logic [CODE_W-1:0]  code);
      logic [TABLE_W-1:0] shifted;
      shifted = table_v >> {code, 1'b0};
      if (code > MAX_TABLE_CODE) begin
         return DEFAULT_CLASS;
      end
      return shifted[CLASS_W-1:0];
   endfunction

   // True when a strictly outranks b on class, then age, then sex.
   function automatic logic outranks(input entry_type a, input entry_type b);
      if (a.cls != b.cls) begin
         return a.cls > b.cls;
      end
      if (a.age != b.age) begin
         return a.age > b.age;
      end
      return a.female && !b.female;
   endfunction

endpackage

>>> rtl/mkpq_cell.sv
// ----------------------------------------------------------------------------
// mkpq_cell: one slot of the sorted chain
// Holds one entry, compares it with the broadcast entry and shifts toward the
// tail on an insert or toward the head on a serve.
// ----------------------------------------------------------------------------
module mkpq_cell (
   input  logic                clock,
   input  logic                reset,
   input  mkpq_pkg::op_type    op,
   input  mkpq_pkg::entry_type new_entry,
   input  mkpq_pkg::link_type  left_link,
   input  mkpq_pkg::link_type  right_link,
   output mkpq_pkg::link_type  own_link
);

   logic                valid_ff;
   logic                valid_in;
   mkpq_pkg::entry_type entry_ff;
   mkpq_pkg::entry_type entry_in;
   logic                beaten;

   // An empty slot or a weaker entry gives way to the new one.
   assign beaten = !valid_ff || mkpq_pkg::outranks(new_entry, entry_ff);

   always_comb begin
      own_link.valid  = valid_ff;
      own_link.beaten = beaten;
      own_link.entry  = entry_ff;
   end

   // Next contents: take the new entry at the boundary, the left neighbor
   // behind it, or the right neighbor when the head is removed.
   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (op.insert) begin
         if (beaten && !left_link.beaten) begin
            valid_in = 1'b1;
            entry_in = new_entry;
         end else if (beaten) begin
            valid_in = left_link.valid;
            entry_in = left_link.entry;
         end
      end else if (op.serve) begin
         valid_in = right_link.valid;
         entry_in = right_link.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

>>> rtl/multi_key_priority_queue.sv
// ----------------------------------------------------------------------------
// multi_key_priority_queue: bounded priority queue in a chain of sorted cells
// The output register holds a result while the next request is taken.
// Throughput: one request per cycle unless a held result stalls; every cell
// compares and shifts in the same cycle.
// Reset: clears all cell valid bits, the entry count and the result valid flag,
// and loads the class table with its default; no clearing pass is needed.
// ----------------------------------------------------------------------------
module multi_key_priority_queue (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // tag[15:0], age[22:16], is_female[23],
                                   // complaint_code[27:24], zero[31:28]
   input  logic [0:0]  req_tuser,  // cmd[0]
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // out_tag[15:0], out_age[22:16], out_female[23],
                                   // out_class[25:24], occupancy[30:26], zero[31]
   output logic [1:0]  rsp_tuser,  // status[1:0]
   // Class table write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [19:0] csr_data
);

   localparam int N = mkpq_pkg::CAPACITY;

   logic [mkpq_pkg::TABLE_W-1:0] table_ff;
   logic [mkpq_pkg::COUNT_W-1:0] count_ff;
   logic [mkpq_pkg::COUNT_W-1:0] count_in;
   logic                         rsp_valid_ff;
   logic [31:0]                  rsp_data_ff;
   logic [31:0]                  rsp_data_in;
   logic [1:0]                   rsp_user_ff;
   mkpq_pkg::status_type         status;
   logic [mkpq_pkg::CLASS_W-1:0] out_class;
   mkpq_pkg::entry_type          served;

   logic                req_xfer;
   logic                is_serve;
   logic                full;
   logic                empty;
   mkpq_pkg::op_type    op;
   mkpq_pkg::entry_type new_entry;
   mkpq_pkg::link_type  links [N];
   mkpq_pkg::link_type  head_side;
   mkpq_pkg::link_type  tail_side;

   // Handshakes.
   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;
   assign is_serve   = (req_tuser[0] == mkpq_pkg::CMD_SERVE);
   assign full       = (count_ff == mkpq_pkg::COUNT_W'(N));
   assign empty      = (count_ff == '0);

   // Class table register.
   always_ff @(posedge clock) begin
      if (reset) begin
         table_ff <= mkpq_pkg::TABLE_RESET;
      end else if (csr_valid && csr_ready) begin
         table_ff <= csr_data;
      end
   end

   // Incoming entry with its looked-up class.
   always_comb begin
      new_entry.tag    = req_tdata[15:0];
      new_entry.age    = req_tdata[22:16];
      new_entry.female = req_tdata[23];
      new_entry.cls    = mkpq_pkg::lookup_class(table_ff, req_tdata[27:24]);
   end

   // Operation for the chain; a full insert or an empty serve leaves it alone.
   always_comb begin
      op.insert = req_xfer && !is_serve && !full;
      op.serve  = req_xfer && is_serve && !empty;
   end

   // Boundary links: nothing ahead of the head, nothing valid past the tail.
   always_comb begin
      head_side.valid  = 1'b1;
      head_side.beaten = 1'b0;
      head_side.entry  = '0;
      tail_side.valid  = 1'b0;
      tail_side.beaten = 1'b1;
      tail_side.entry  = '0;
   end

   // The chain of cells, head first.
   for (genvar i = 0; i < N; i++) begin : g_cell
      mkpq_pkg::link_type left_l;
      mkpq_pkg::link_type right_l;
      if (i == 0) begin : g_head
         assign left_l = head_side;
      end else begin : g_mid_l
         assign left_l = links[i-1];
      end
      if (i == N - 1) begin : g_tail
         assign right_l = tail_side;
      end else begin : g_mid_r
         assign right_l = links[i+1];
      end
      mkpq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (op),
         .new_entry  (new_entry),
         .left_link  (left_l),
         .right_link (right_l),
         .own_link   (links[i])
      );
   end

   // Entry count.
   always_comb begin
      count_in = count_ff;
      if (op.insert) begin
         count_in = count_ff + mkpq_pkg::COUNT_W'(1);
      end else if (op.serve) begin
         count_in = count_ff - mkpq_pkg::COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Result fields for the current transfer.
   always_comb begin
      served    = '0;
      out_class = new_entry.cls;
      if (!is_serve) begin
         status = full ? mkpq_pkg::ST_DROPPED : mkpq_pkg::ST_INSERTED;
      end else if (empty) begin
         status    = mkpq_pkg::ST_EMPTY;
         out_class = '0;
      end else begin
         status    = mkpq_pkg::ST_SERVED;
         served    = links[0].entry;
         out_class = links[0].entry.cls;
      end
      rsp_data_in = {1'b0, mkpq_pkg::OCC_W'(count_in), out_class,
                     served.female, served.age, served.tag};
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

>>> tb/mkpq_checker.sv
// ----------------------------------------------------------------------------
// mkpq_checker: result checker for the multi-key priority queue
// Watches the request, result and class table channels. It keeps its own
// sorted waiting line and class map, works out the result of every request
// transfer and compares each result transfer, field by field, with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module mkpq_checker
   import mkpq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [31:0]        req_tdata,
   input  logic [0:0]         req_tuser,
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [31:0]        rsp_tdata,
   input  logic [1:0]         rsp_tuser,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [TABLE_W-1:0] csr_data,
   output int unsigned        error_count,
   output int unsigned        awaiting,
   output int unsigned        inserted_count,
   output int unsigned        served_count,
   output int unsigned        empty_count,
   output int unsigned        dropped_count
);

   timeunit 1ns;
   timeprecision 1ps;

   // One predicted result of the queue.
   typedef struct packed {
      status_type         status;
      logic [TAG_W-1:0]   tag;
      logic [AGE_W-1:0]   age;
      logic               female;
      logic [CLASS_W-1:0] cls;
      logic [OCC_W-1:0]   occupancy;
   } triage_result;

   entry_type          waiting_line [CAPACITY];
   int unsigned        line_count;
   logic [TABLE_W-1:0] class_map;
   triage_result       predicted_results [$];

   int unsigned errors;
   int unsigned n_inserted;
   int unsigned n_served;
   int unsigned n_empty;
   int unsigned n_dropped;

   initial begin
      error_count    = 0;
      awaiting       = 0;
      inserted_count = 0;
      served_count   = 0;
      empty_count    = 0;
      dropped_count  = 0;
      errors         = 0;
      n_inserted     = 0;
      n_served       = 0;
      n_empty        = 0;
      n_dropped      = 0;
      line_count     = 0;
      class_map      = TABLE_RESET;
   end

   // Severity class of a complaint code under the current class map.
   function automatic logic [CLASS_W-1:0] severity_of(input logic [CODE_W-1:0] code);
      if (code > MAX_TABLE_CODE) begin
         return DEFAULT_CLASS;
      end
      return class_map[2 * code +: CLASS_W];
   endfunction

   // A patient goes ahead of another only on a strictly better rank.
   function automatic logic ranks_above(input entry_type a, input entry_type b);
      if (a.cls != b.cls) begin
         return a.cls > b.cls;
      end
      if (a.age != b.age) begin
         return a.age > b.age;
      end
      return (a.female == 1'b1) && (b.female == 1'b0);
   endfunction

   // Apply one request to the waiting line and return what the queue reports.
   function automatic triage_result admit_request(input logic cmd, input logic [31:0] data);
      triage_result r;
      entry_type    arrival;
      int unsigned  slot;
      logic         placed;
      int           i;
      r = '0;
      if (cmd == CMD_INSERT) begin
         arrival.tag    = data[15:0];
         arrival.age    = data[22:16];
         arrival.female = data[23];
         arrival.cls    = severity_of(data[27:24]);
         r.cls          = arrival.cls;
         if (line_count >= CAPACITY) begin
            r.status = ST_DROPPED;
            n_dropped++;
         end else begin
            // The arrival goes in front of the first entry it strictly beats.
            slot   = line_count;
            placed = 1'b0;
            for (i = 0; i < line_count; i++) begin
               if (!placed && ranks_above(arrival, waiting_line[i])) begin
                  slot   = i;
                  placed = 1'b1;
               end
            end
            for (i = CAPACITY - 1; i > 0; i--) begin
               if (i > slot && i <= line_count) begin
                  waiting_line[i] = waiting_line[i-1];
               end
            end
            waiting_line[slot] = arrival;
            line_count++;
            r.status = ST_INSERTED;
            n_inserted++;
         end
      end else begin
         if (line_count == 0) begin
            r.status = ST_EMPTY;
            n_empty++;
         end else begin
            r.tag    = waiting_line[0].tag;
            r.age    = waiting_line[0].age;
            r.female = waiting_line[0].female;
            r.cls    = waiting_line[0].cls;
            for (i = 1; i < CAPACITY; i++) begin
               if (i < line_count) begin
                  waiting_line[i-1] = waiting_line[i];
               end
            end
            line_count--;
            r.status = ST_SERVED;
            n_served++;
         end
      end
      r.occupancy = line_count[OCC_W-1:0];
      return r;
   endfunction

   // Count a mismatch; only the first few are described.
   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         errors++;
         if (errors <= 10) begin
            $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, field,
                     want, got);
         end
      end
   endtask

   // Prediction and comparison, sampled on the rising edge.
   always @(posedge clock) begin
      triage_result wanted;
      if (reset) begin
         line_count = 0;
         class_map  = TABLE_RESET;
         predicted_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            class_map = csr_data;
         end
         if (req_tvalid && req_tready) begin
            predicted_results.push_back(admit_request(req_tuser[0], req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_results.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("%0t: result transfer with no prediction outstanding", $realtime);
               end
            end else begin
               wanted = predicted_results.pop_front();
               check_field("status", wanted.status, rsp_tuser);
               check_field("out_tag", wanted.tag, rsp_tdata[15:0]);
               check_field("out_age", wanted.age, rsp_tdata[22:16]);
               check_field("out_female", wanted.female, rsp_tdata[23]);
               check_field("out_class", wanted.cls, rsp_tdata[25:24]);
               check_field("occupancy", wanted.occupancy, rsp_tdata[30:26]);
            end
         end
      end
      error_count    <= errors;
      awaiting       <= predicted_results.size();
      inserted_count <= n_inserted;
      served_count   <= n_served;
      empty_count    <= n_empty;
      dropped_count  <= n_dropped;
   end

endmodule

>>> tb/tb_multi_key_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_multi_key_priority_queue: testbench of the multi-key priority queue
// Drives a directed fill, overflow and drain with extreme field values and
// rank ties, then random insert and serve traffic that swings between a full
// and an empty queue under several class table settings. The sender works in
// bursts and the receiver stalls on its own pattern; a checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module tb_multi_key_priority_queue;

   timeunit 1ns;
   timeprecision 1ps;

   import mkpq_pkg::*;

   localparam int PHASES         = 8;
   localparam int PHASE_REQUESTS = 235;

   logic               clock;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [31:0]        req_tdata  = '0;
   logic [0:0]         req_tuser  = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [31:0]        rsp_tdata;
   logic [1:0]         rsp_tuser;
   logic               csr_valid  = 1'b0;
   logic               csr_ready;
   logic [TABLE_W-1:0] csr_data   = '0;

   int unsigned error_count;
   int unsigned awaiting;
   int unsigned inserted_count;
   int unsigned served_count;
   int unsigned empty_count;
   int unsigned dropped_count;

   int unsigned burst_left    = 0;
   int unsigned segment_left  = 0;
   int unsigned requests_sent = 0;
   int unsigned table_writes  = 0;

   multi_key_priority_queue i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   mkpq_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .error_count    (error_count),
      .awaiting       (awaiting),
      .inserted_count (inserted_count),
      .served_count   (served_count),
      .empty_count    (empty_count),
      .dropped_count  (dropped_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The receiver alternates long ready runs with short stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         segment_left = 0;
      end else begin
         if (segment_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
               rsp_tready <= 1'b0;
               segment_left = $urandom_range(1, 6);
            end else begin
               rsp_tready <= 1'b1;
               segment_left = $urandom_range(1, 48);
            end
         end
         segment_left = segment_left - 1;
      end
   end

   // One request transfer; a new burst starts after a gap of idle cycles.
   task automatic push_request(input logic cmd, input logic [TAG_W-1:0] tag,
                               input logic [AGE_W-1:0] age, input logic female,
                               input logic [CODE_W-1:0] code);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 30);
      end
      burst_left = burst_left - 1;
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, code, female, age, tag};
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
   endtask

   // Hold off the sender until every predicted result has been received.
   task automatic wait_until_settled();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic load_class_table(input logic [TABLE_W-1:0] value);
      wait_until_settled();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      table_writes++;
   endtask

   // Stimulus and verdict.
   initial begin
      logic [TABLE_W-1:0] settings [PHASES];
      int unsigned        insert_pct;
      int unsigned        run_left;
      logic               cmd;
      logic [AGE_W-1:0]   age;
      int                 p;
      int                 n;
      int                 i;

      settings[0] = 20'h00000;
      settings[1] = 20'hFFFFF;
      settings[2] = TABLE_RESET;
      settings[3] = TABLE_W'($urandom_range(0, 20'hFFFFF));
      settings[4] = 20'h55555;
      settings[5] = TABLE_W'($urandom_range(0, 20'hFFFFF));
      settings[6] = 20'hAAAAA;
      settings[7] = TABLE_W'($urandom_range(0, 20'hFFFFF));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part with the reset class table: serve on an empty queue,
      // fill with every complaint code and extreme fields, overflow, then serve.
      push_request(CMD_SERVE, 16'h0000, 7'd0, 1'b0, 4'd0);
      for (i = 0; i < CAPACITY; i++) begin
         case (i)
            0: begin
               push_request(CMD_INSERT, 16'h0000, 7'd0, 1'b0, 4'd0);
            end
            1: begin
               push_request(CMD_INSERT, 16'hFFFF, 7'd127, 1'b1, 4'd1);
            end
            // Codes 14 and 15 share the default class: with equal age and sex
            // the later arrival must queue behind the earlier one.
            14, 15: begin
               push_request(CMD_INSERT, TAG_W'(32'hA500 + i), 7'd33, 1'b1, CODE_W'(i));
            end
            default: begin
               push_request(CMD_INSERT, TAG_W'($urandom), AGE_W'($urandom_range(0, 127)),
                            i[0], CODE_W'(i));
            end
         endcase
      end
      // The queue is full now, so this insert is dropped.
      push_request(CMD_INSERT, 16'h5A5A, 7'd127, 1'b1, 4'd6);
      repeat (4) push_request(CMD_SERVE, 16'hFFFF, 7'd127, 1'b1, 4'd15);

      // Random part: each class table setting gets traffic that swings between
      // insert-heavy and serve-heavy runs, so the queue fills and empties often.
      for (p = 0; p < PHASES; p++) begin
         load_class_table(settings[p]);
         run_left = 0;
         for (n = 0; n < PHASE_REQUESTS; n++) begin
            if (run_left == 0) begin
               run_left = $urandom_range(15, 60);
               case ($urandom_range(0, 2))
                  0:       insert_pct = 80;
                  1:       insert_pct = 25;
                  default: insert_pct = 50;
               endcase
            end
            run_left = run_left - 1;
            cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_SERVE;
            // Half of the ages come from a small set so that rank ties are common.
            case ($urandom_range(0, 7))
               0:       age = 7'd0;
               1:       age = 7'd127;
               2:       age = 7'd40;
               3:       age = 7'd41;
               default: age = AGE_W'($urandom_range(0, 127));
            endcase
            push_request(cmd, TAG_W'($urandom), age, 1'($urandom_range(0, 1)),
                         CODE_W'($urandom_range(0, 15)));
         end
      end

      wait_until_settled();
      repeat (4) @(posedge clock);

      $display("Covered %0d requests over %0d class table settings:", requests_sent,
               table_writes + 1);
      $display("%0d inserted, %0d served, %0d serves on empty, %0d inserts dropped.",
               inserted_count, served_count, empty_count, dropped_count);
      if (error_count == 0 && awaiting == 0) begin
         $display("tb_multi_key_priority_queue passed");
      end else begin
         $display("tb_multi_key_priority_queue failed");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2_000_000;
      $display("Timeout: the run did not complete in time.");
      $display("tb_multi_key_priority_queue failed");
      $finish;
   end

endmodule
